// ----- rtl/assert_macros.svh -----
// Assertion macros used by the signal-loss filter datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rcslf_pkg.sv -----
// Shared types and constants of the receiver channel signal-loss filter
package rcslf_pkg;

   localparam int CHANNELS_DEF    = 18;
   localparam int AVG_SAMPLES_DEF = 3;

   localparam int CHAN_W   = 5;
   localparam int VAL_W    = 16;
   localparam int TIME_W   = 32;
   localparam int US_W     = 12;
   localparam int HOLD_W   = 16;
   localparam int CNT_W    = 5;
   localparam int FLIGHT_W = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [FLIGHT_W-1:0] FLIGHT_ALL      = 4'hF;
   localparam logic [CHAN_W-1:0]   THROTTLE_CH     = 5'd3;
   localparam logic [CHAN_W-1:0]   FLIGHT_CHANNELS = 5'd4;

   localparam logic [US_W-1:0]   MID_RESET      = 12'd1500;
   localparam logic [US_W-1:0]   MIN_RESET      = 12'd885;
   localparam logic [US_W-1:0]   MAX_RESET      = 12'd2115;
   localparam logic [HOLD_W-1:0] HOLD_MS_RESET  = 16'd300;
   localparam logic [CNT_W-1:0]  CH_COUNT_RESET = 5'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_MIN   = 3'd0,
      CSR_PULSE_MAX   = 3'd1,
      CSR_MID         = 3'd2,
      CSR_HOLD        = 3'd3,
      CSR_THREE_D     = 3'd4,
      CSR_FS_ENABLE   = 3'd5,
      CSR_AVERAGING   = 3'd6,
      CSR_CHAN_COUNT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [US_W-1:0]   pulse_min_us;
      logic [US_W-1:0]   pulse_max_us;
      logic [US_W-1:0]   mid_us;
      logic [HOLD_W-1:0] hold_ms;
      logic              three_d_mode;
      logic              failsafe_enabled;
      logic              averaging_mode;
      logic [CNT_W-1:0]  channel_count;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_index;
      logic [VAL_W-1:0]  pulse_us;
      logic [TIME_W-1:0] now_ms;
      logic              link_ok;
      logic              failsafe_switch;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_channel;
      logic [VAL_W-1:0]  out_value;
      logic              is_override;
      logic              flight_ok;
      logic              run_last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic sum_rd;
      logic sum_acc;
      logic mul;
      logic quo;
      logic emit0;
      logic run_rd;
      logic run_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic avg_go;
      logic override;
      logic out_free;
      logic run_last;
   } status_type;

endpackage

// ----- rtl/rcslf_ctrl.sv -----
// Sequencing state machine of the signal-loss filter
module rcslf_ctrl #(
   parameter int CHANNELS    = rcslf_pkg::CHANNELS_DEF,
   parameter int AVG_SAMPLES = rcslf_pkg::AVG_SAMPLES_DEF,
   parameter int STEP_W      = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rcslf_pkg::status_type  status,
   output rcslf_pkg::cmd_type     cmd,
   output logic [STEP_W-1:0]      step
);
   import rcslf_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_EVAL    = 8'b0000_0010,
      ST_SUM     = 8'b0000_0100,
      ST_MUL     = 8'b0000_1000,
      ST_QUO     = 8'b0001_0000,
      ST_EMIT    = 8'b0010_0000,
      ST_RUN_RD  = 8'b0100_0000,
      ST_RUN_OUT = 8'b1000_0000
   } state_type;

   localparam logic [STEP_W-1:0] AVG_N = STEP_W'(AVG_SAMPLES);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            step_in  = '0;
            state_in = status.avg_go ? ST_SUM : ST_EMIT;
         end
         ST_SUM: begin
            // read slot step, accumulate the slot read in the previous cycle
            cmd.sum_rd  = (step_ff < AVG_N);
            cmd.sum_acc = (step_ff != '0);
            if (step_ff == AVG_N) begin
               state_in = ST_MUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_QUO;
         end
         ST_QUO: begin
            cmd.quo  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit0 = 1'b1;
               step_in   = '0;
               state_in  = status.override ? ST_RUN_RD : ST_IDLE;
            end
         end
         ST_RUN_RD: begin
            cmd.run_rd = 1'b1;
            state_in   = ST_RUN_OUT;
         end
         ST_RUN_OUT: begin
            if (status.out_free) begin
               cmd.run_out = 1'b1;
               if (status.run_last) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_RUN_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign step      = step_ff;

endmodule

// ----- rtl/rcslf_datapath.sv -----
// Channel stores, averaging arithmetic and result register of the signal-loss filter
`include "assert_macros.svh"
module rcslf_datapath #(
   parameter int CHANNELS    = rcslf_pkg::CHANNELS_DEF,
   parameter int AVG_SAMPLES = rcslf_pkg::AVG_SAMPLES_DEF,
   parameter int STEP_W      = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rcslf_pkg::req_type    req_data,
   input  rcslf_pkg::cfg_type    cfg,
   input  rcslf_pkg::cmd_type    cmd,
   input  logic [STEP_W-1:0]     step,
   output rcslf_pkg::status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rcslf_pkg::rsp_type    rsp_data
);
   import rcslf_pkg::*;

   localparam int CH_W    = $clog2(CHANNELS);
   localparam int RING_D  = CHANNELS * AVG_SAMPLES;
   localparam int RING_AW = $clog2(RING_D);
   localparam int SLOT_W  = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
   localparam int FR_W    = $clog2(AVG_SAMPLES + 1);
   localparam int SUM_W   = VAL_W + $clog2(AVG_SAMPLES);
   localparam int RECIP_K = SUM_W + 4;
   localparam int RECIP_W = RECIP_K + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int CMP_W   = CHAN_W + 1;

   // ceiling reciprocal: exact floor division for every sum below 2**SUM_W
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_K) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));
   localparam logic [CMP_W-1:0]  CHANNELS_C = CMP_W'(CHANNELS);
   localparam logic [FR_W-1:0]   AVG_N      = FR_W'(AVG_SAMPLES);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(AVG_SAMPLES - 1);
   localparam logic [VAL_W-1:0]  THR_RESET  = VAL_W'(MIN_RESET);
   localparam logic [VAL_W-1:0]  MID_RST_V  = VAL_W'(MID_RESET);
   localparam logic [TIME_W-1:0] DL_RESET   = TIME_W'(HOLD_MS_RESET);

   function automatic logic [VAL_W-1:0] fail_value(input logic [CHAN_W-1:0] ch,
                                                   input logic [VAL_W-1:0]  held,
                                                   input cfg_type           c);
      logic [VAL_W-1:0] result;
      if (ch < THROTTLE_CH) begin
         result = VAL_W'(c.mid_us);
      end else if (ch == THROTTLE_CH) begin
         result = c.three_d_mode ? VAL_W'(c.mid_us) : VAL_W'(c.pulse_min_us);
      end else begin
         result = held;
      end
      return result;
   endfunction

   req_type              item_ff;
   logic [VAL_W-1:0]     cv_mem [CHANNELS];
   logic [CHANNELS-1:0]  cv_vld_ff;
   logic [VAL_W-1:0]     cv_rd_ff;
   logic [TIME_W-1:0]    dl_mem [CHANNELS];
   logic [CHANNELS-1:0]  dl_vld_ff;
   logic [TIME_W-1:0]    dl_rd_ff;
   logic [VAL_W-1:0]     ring_mem [RING_D];
   logic [RING_D-1:0]    ring_vld_ff;
   logic [VAL_W-1:0]     ring_rd_ff;
   logic [VAL_W-1:0]     s_ff;
   logic [SUM_W-1:0]     acc_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [FLIGHT_W-1:0]  mask_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [FR_W-1:0]      frames_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 req_in_range, in_range;
   logic [CH_W-1:0]      rd_addr, ch_a;
   logic                 pulse_ok, hold, flight_ok;
   logic [TIME_W:0]      dl_sum;
   logic [TIME_W-1:0]    dl_new;
   logic [VAL_W-1:0]     s_next;
   logic [RING_AW-1:0]   ring_wa, ring_ra;
   logic [CHAN_W-1:0]    run_ch;
   logic [VAL_W-1:0]     run_val;
   logic [CMP_W-1:0]     cnt, step_p1;
   logic                 run_last, override, out_free, adv;
   logic                 cv_we;
   logic [CH_W-1:0]      cv_wa;
   logic [VAL_W-1:0]     cv_wd;

   assign req_in_range = {1'b0, req_data.chan_index} < CHANNELS_C;
   assign in_range     = {1'b0, item_ff.chan_index} < CHANNELS_C;
   assign ch_a         = item_ff.chan_index[CH_W-1:0];
   assign rd_addr      = cmd.load ? (req_in_range ? req_data.chan_index[CH_W-1:0] : '0)
                                  : step[CH_W-1:0];

   // item evaluation
   assign pulse_ok = item_ff.link_ok
                     && (item_ff.pulse_us >= VAL_W'(cfg.pulse_min_us))
                     && (item_ff.pulse_us <= VAL_W'(cfg.pulse_max_us));
   assign hold     = item_ff.now_ms < dl_rd_ff;
   assign dl_sum   = {1'b0, item_ff.now_ms} + (TIME_W + 1)'(cfg.hold_ms);
   assign dl_new   = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

   always_comb begin
      if (pulse_ok) begin
         s_next = item_ff.pulse_us;
      end else if (hold) begin
         s_next = cv_rd_ff;
      end else begin
         s_next = fail_value(item_ff.chan_index, cv_rd_ff, cfg);
      end
   end

   assign ring_wa = RING_AW'(ch_a) * RING_AW'(AVG_SAMPLES) + RING_AW'(slot_ff);
   assign ring_ra = RING_AW'(ch_a) * RING_AW'(AVG_SAMPLES) + RING_AW'(step);

   // override run
   assign run_ch  = CHAN_W'(step);
   assign run_val = fail_value(run_ch, cv_rd_ff, cfg);
   always_comb begin
      if (cfg.channel_count == '0) begin
         cnt = CMP_W'(1);
      end else if ({1'b0, cfg.channel_count} > CHANNELS_C) begin
         cnt = CHANNELS_C;
      end else begin
         cnt = {1'b0, cfg.channel_count};
      end
   end
   assign step_p1  = CMP_W'(step) + 1'b1;
   assign run_last = (step_p1 == cnt);

   assign flight_ok = (mask_ff == FLIGHT_ALL);
   assign override  = item_ff.frame_end
                      && (!flight_ok || (item_ff.failsafe_switch && cfg.failsafe_enabled));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign adv       = (cmd.emit0 && !override && item_ff.frame_end)
                      || (cmd.run_out && run_last);

   assign status.avg_go   = cfg.averaging_mode && in_range && (frames_ff >= AVG_N);
   assign status.override = override;
   assign status.out_free = out_free;
   assign status.run_last = run_last;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   // channel value store
   always_comb begin
      cv_we = cmd.emit0 && in_range;
      cv_wa = ch_a;
      cv_wd = s_ff;
      if (cmd.run_out && (run_ch < FLIGHT_CHANNELS)) begin
         cv_we = 1'b1;
         cv_wa = step[CH_W-1:0];
         cv_wd = run_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cv_we) begin
         cv_mem[cv_wa] <= cv_wd;
      end
      if (cmd.load || cmd.run_rd) begin
         if (cv_vld_ff[rd_addr]) begin
            cv_rd_ff <= cv_mem[rd_addr];
         end else begin
            cv_rd_ff <= (CHAN_W'(rd_addr) == THROTTLE_CH) ? THR_RESET : MID_RST_V;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_vld_ff <= '0;
      end else if (cv_we) begin
         cv_vld_ff[cv_wa] <= 1'b1;
      end
   end

   // hold deadline store
   always_ff @(posedge clock) begin
      if (cmd.eval && in_range && pulse_ok) begin
         dl_mem[ch_a] <= dl_new;
      end
      if (cmd.load) begin
         dl_rd_ff <= dl_vld_ff[rd_addr] ? dl_mem[rd_addr] : DL_RESET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_vld_ff <= '0;
      end else if (cmd.eval && in_range && pulse_ok) begin
         dl_vld_ff[ch_a] <= 1'b1;
      end
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (cmd.eval && in_range && cfg.averaging_mode) begin
         ring_mem[ring_wa] <= s_next;
      end
      if (cmd.sum_rd) begin
         ring_rd_ff <= ring_vld_ff[ring_ra] ? ring_mem[ring_ra] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
      end else if (cmd.eval && in_range && cfg.averaging_mode) begin
         ring_vld_ff[ring_wa] <= 1'b1;
      end
   end

   // sample value, sum and mean
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         s_ff   <= s_next;
         acc_ff <= '0;
      end else begin
         if (cmd.sum_acc) begin
            acc_ff <= acc_ff + SUM_W'(ring_rd_ff);
         end
         if (cmd.quo) begin
            s_ff <= prod_ff[RECIP_K +: VAL_W];
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(acc_ff) * PROD_W'(RECIP);
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= FLIGHT_ALL;
         slot_ff   <= '0;
         frames_ff <= '0;
      end else begin
         if (adv) begin
            mask_ff   <= FLIGHT_ALL;
            slot_ff   <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            if (frames_ff < AVG_N) begin
               frames_ff <= frames_ff + 1'b1;
            end
         end else if (cmd.eval && in_range && !pulse_ok && !hold
                      && (item_ff.chan_index < FLIGHT_CHANNELS)) begin
            // flight channel reached failsafe: mark it bad for this frame
            mask_ff[item_ff.chan_index[1:0]] <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit0 || cmd.run_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit0) begin
         rsp_data_ff.out_channel <= item_ff.chan_index;
         rsp_data_ff.out_value   <= in_range ? s_ff : '0;
         rsp_data_ff.is_override <= 1'b0;
         rsp_data_ff.flight_ok   <= flight_ok;
         rsp_data_ff.run_last    <= !override;
      end else if (cmd.run_out) begin
         rsp_data_ff.out_channel <= run_ch;
         rsp_data_ff.out_value   <= run_val;
         rsp_data_ff.is_override <= 1'b1;
         rsp_data_ff.flight_ok   <= flight_ok;
         rsp_data_ff.run_last    <= run_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_mask_restored, adv, mask_ff == FLIGHT_ALL, "flight mask kept after frame end")
   `ASSERT_HOLDS(a_frames_bound, frames_ff <= AVG_N, "frame counter passed its limit")
   `ASSERT_IMPLIES(a_emit_room, cmd.emit0 || cmd.run_out, out_free, "result overwrote a transaction")

endmodule

// ----- rtl/rc_channel_signal_loss_filter.sv -----
// Result 0: the item is loaded, evaluated in ST_EVAL and registered in ST_EMIT when the
//   result register is free; active averaging adds ST_SUM (one ring slot per cycle through a
//   single read port), ST_MUL and ST_QUO. A new item is taken only back in ST_IDLE; an
//   override run reads then emits each channel on the single channel-value read port.
// Reset (synchronous, active high): registers back to defaults, all stores read as reset
//   values at once through per-entry valid bits; no clearing pass.
module rc_channel_signal_loss_filter #(
   parameter int CHANNELS    = rcslf_pkg::CHANNELS_DEF,
   parameter int AVG_SAMPLES = rcslf_pkg::AVG_SAMPLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rcslf_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rcslf_pkg::rsp_type               rsp_data,
   input  logic                             csr_we,
   input  logic [rcslf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcslf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rcslf_pkg::*;

   localparam int STEP_MAX = (CHANNELS > AVG_SAMPLES) ? CHANNELS : AVG_SAMPLES;
   localparam int STEP_W   = $clog2(STEP_MAX + 1);

   cfg_type           cfg_ff, cfg_in;
   cmd_type           cmd;
   status_type        status;
   logic [STEP_W-1:0] step;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PULSE_MIN:  cfg_in.pulse_min_us     = csr_wdata[US_W-1:0];
            CSR_PULSE_MAX:  cfg_in.pulse_max_us     = csr_wdata[US_W-1:0];
            CSR_MID:        cfg_in.mid_us           = csr_wdata[US_W-1:0];
            CSR_HOLD:       cfg_in.hold_ms          = csr_wdata[HOLD_W-1:0];
            CSR_THREE_D:    cfg_in.three_d_mode     = csr_wdata[0];
            CSR_FS_ENABLE:  cfg_in.failsafe_enabled = csr_wdata[0];
            CSR_AVERAGING:  cfg_in.averaging_mode   = csr_wdata[0];
            CSR_CHAN_COUNT: cfg_in.channel_count    = csr_wdata[CNT_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min_us     <= MIN_RESET;
         cfg_ff.pulse_max_us     <= MAX_RESET;
         cfg_ff.mid_us           <= MID_RESET;
         cfg_ff.hold_ms          <= HOLD_MS_RESET;
         cfg_ff.three_d_mode     <= 1'b0;
         cfg_ff.failsafe_enabled <= 1'b1;
         cfg_ff.averaging_mode   <= 1'b0;
         cfg_ff.channel_count    <= CH_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcslf_ctrl #(
      .CHANNELS    (CHANNELS),
      .AVG_SAMPLES (AVG_SAMPLES),
      .STEP_W      (STEP_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .step      (step)
   );

   rcslf_datapath #(
      .CHANNELS    (CHANNELS),
      .AVG_SAMPLES (AVG_SAMPLES),
      .STEP_W      (STEP_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .step      (step),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- bench/tb.sv -----
// Testbench of the receiver channel signal-loss filter: directed and random frames
`timescale 1ns / 100ps

module tb;
   import rcslf_pkg::*;

   localparam int NUM_CH  = CHANNELS_DEF;
   localparam int NUM_AVG = AVG_SAMPLES_DEF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rc_channel_signal_loss_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // filter state as the block should hold it
   cfg_type            cfg_now;
   logic [VAL_W-1:0]   held_value [NUM_CH];
   logic [TIME_W-1:0]  hold_until [NUM_CH];
   logic [VAL_W-1:0]   sample_hist [NUM_CH*NUM_AVG];
   int                 hist_slot;
   int                 frames_done;
   logic [FLIGHT_W-1:0] flight_good;
   rsp_type            due_results [$];

   int                 mismatches = 0;
   bit                 req_idle_on = 1'b1;
   bit                 rsp_idle_on = 1'b1;
   logic [TIME_W-1:0]  frame_ms = '0;
   bit                 link_up = 1'b1;

   function automatic cfg_type default_cfg();
      cfg_type c;
      c.pulse_min_us     = MIN_RESET;
      c.pulse_max_us     = MAX_RESET;
      c.mid_us           = MID_RESET;
      c.hold_ms          = HOLD_MS_RESET;
      c.three_d_mode     = 1'b0;
      c.failsafe_enabled = 1'b1;
      c.averaging_mode   = 1'b0;
      c.channel_count    = CH_COUNT_RESET;
      return c;
   endfunction

   function automatic void clear_filter_state();
      cfg_now = default_cfg();
      for (int i = 0; i < NUM_CH; i++) begin
         held_value[i] = {4'b0, MID_RESET};
         hold_until[i] = TIME_W'(HOLD_MS_RESET);
      end
      held_value[THROTTLE_CH] = {4'b0, MIN_RESET};
      for (int i = 0; i < NUM_CH*NUM_AVG; i++)
         sample_hist[i] = '0;
      hist_slot   = 0;
      frames_done = 0;
      flight_good = FLIGHT_ALL;
   endfunction

   function automatic logic [VAL_W-1:0] failsafe_level(input int ch);
      if (ch < int'(THROTTLE_CH))
         return {4'b0, cfg_now.mid_us};
      if (ch == int'(THROTTLE_CH))
         return {4'b0, cfg_now.three_d_mode ? cfg_now.mid_us : cfg_now.pulse_min_us};
      return held_value[ch];
   endfunction

   // work out every result one accepted transaction causes
   function automatic void filter_channel(input req_type r);
      int                 ch;
      int                 run_len;
      logic               valid;
      logic [VAL_W-1:0]   s;
      logic [VAL_W-1:0]   f;
      logic [TIME_W:0]    d;
      logic [VAL_W+1:0]   sum;
      logic               ok;
      rsp_type            o;
      ch = int'(r.chan_index);
      s  = '0;
      if (ch < NUM_CH) begin
         valid = r.link_ok && r.pulse_us >= cfg_now.pulse_min_us
                 && r.pulse_us <= cfg_now.pulse_max_us;
         s = r.pulse_us;
         if (!valid) begin
            if (r.now_ms < hold_until[ch]) begin
               s = held_value[ch];
            end else begin
               s = failsafe_level(ch);
               if (ch < int'(FLIGHT_CHANNELS))
                  flight_good[ch] = 1'b0;
            end
         end else begin
            d = {1'b0, r.now_ms} + cfg_now.hold_ms;
            hold_until[ch] = d[TIME_W] ? '1 : d[TIME_W-1:0];
         end
         if (cfg_now.averaging_mode) begin
            sample_hist[ch*NUM_AVG + hist_slot] = s;
            if (frames_done >= NUM_AVG) begin
               sum = '0;
               for (int j = 0; j < NUM_AVG; j++)
                  sum += sample_hist[ch*NUM_AVG + j];
               s = VAL_W'(sum / NUM_AVG);
            end
         end
         held_value[ch] = s;
      end
      ok = (flight_good == FLIGHT_ALL);
      o.out_channel = r.chan_index;
      o.out_value   = s;
      o.is_override = 1'b0;
      o.flight_ok   = ok;
      if (r.frame_end && (!ok || (r.failsafe_switch && cfg_now.failsafe_enabled))) begin
         run_len = int'(cfg_now.channel_count);
         if (run_len < 1) run_len = 1;
         if (run_len > NUM_CH) run_len = NUM_CH;
         o.run_last = 1'b0;
         due_results.push_back(o);
         for (int c = 0; c < run_len; c++) begin
            f = failsafe_level(c);
            held_value[c] = f;
            o.out_channel = CHAN_W'(c);
            o.out_value   = f;
            o.is_override = 1'b1;
            o.run_last    = (c + 1 == run_len);
            due_results.push_back(o);
         end
      end else begin
         o.run_last = 1'b1;
         due_results.push_back(o);
      end
      if (r.frame_end) begin
         flight_good = FLIGHT_ALL;
         hist_slot   = (hist_slot + 1) % NUM_AVG;
         if (frames_done < NUM_AVG)
            frames_done++;
      end
   endfunction

   // result side: random stalls, checked against the oldest expectation
   always @(posedge clock) begin
      rsp_stall <= rsp_idle_on && ($urandom_range(0, 99) < 25);
   end

   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected result: ch %0d value %0d ovr %0b ok %0b last %0b",
                        rsp_data.out_channel, rsp_data.out_value, rsp_data.is_override,
                        rsp_data.flight_ok, rsp_data.run_last);
         end else begin
            want = due_results.pop_front();
            if (rsp_data.out_channel !== want.out_channel
                || rsp_data.out_value !== want.out_value
                || rsp_data.is_override !== want.is_override
                || rsp_data.flight_ok !== want.flight_ok
                || rsp_data.run_last !== want.run_last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("tb: mismatch: expected ch %0d value %0d ovr %0b ok %0b last %0b",
                           want.out_channel, want.out_value, want.is_override,
                           want.flight_ok, want.run_last);
                  $display("tb:           got ch %0d value %0d ovr %0b ok %0b last %0b",
                           rsp_data.out_channel, rsp_data.out_value, rsp_data.is_override,
                           rsp_data.flight_ok, rsp_data.run_last);
               end
            end
         end
      end
   end

   // present one transaction, hold it until taken, then predict
   task automatic send_txn(input req_type item);
      bit taken;
      while (req_idle_on && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      filter_channel(item);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_cfg(input cfg_type c);
      write_reg(CSR_PULSE_MIN, CSR_DATA_W'(c.pulse_min_us));
      write_reg(CSR_PULSE_MAX, CSR_DATA_W'(c.pulse_max_us));
      write_reg(CSR_MID, CSR_DATA_W'(c.mid_us));
      write_reg(CSR_HOLD, CSR_DATA_W'(c.hold_ms));
      write_reg(CSR_THREE_D, CSR_DATA_W'(c.three_d_mode));
      write_reg(CSR_FS_ENABLE, CSR_DATA_W'(c.failsafe_enabled));
      write_reg(CSR_AVERAGING, CSR_DATA_W'(c.averaging_mode));
      write_reg(CSR_CHAN_COUNT, CSR_DATA_W'(c.channel_count));
      csr_we <= 1'b0;
      cfg_now = c;
   endtask

   function automatic req_type make_req(input int ch, input int pulse, input logic [31:0] now,
                                        input bit link, input bit sw, input bit fend);
      req_type r;
      r.chan_index      = CHAN_W'(ch);
      r.pulse_us        = VAL_W'(pulse);
      r.now_ms          = now;
      r.link_ok         = link;
      r.failsafe_switch = sw;
      r.frame_end       = fend;
      return r;
   endfunction

   // first frames after reset pass raw samples, later ones are means of three
   task automatic test_averaging_warmup();
      cfg_type c;
      c = default_cfg();
      c.averaging_mode = 1'b1;
      c.channel_count  = 5'd2;
      c.hold_ms        = 16'd30;
      apply_cfg(c);
      for (int f = 0; f < 5; f++) begin
         send_txn(make_req(0, 1000 + f*137, 1000 + f*20, 1'b1, 1'b0, 1'b0));
         send_txn(make_req(3, 1900 - f*91, 1000 + f*20, f < 3, 1'b0, 1'b1));
      end
      drain_results();
   endtask

   task automatic test_signal_loss_directed();
      apply_cfg(default_cfg());
      send_txn(make_req(0, 885, 0, 1'b1, 1'b0, 1'b0));
      send_txn(make_req(1, 2115, 0, 1'b1, 1'b0, 1'b0));
      send_txn(make_req(2, 884, 10, 1'b1, 1'b0, 1'b0));
      send_txn(make_req(3, 2116, 20, 1'b1, 1'b0, 1'b1));
      send_txn(make_req(4, 0, 100, 1'b0, 1'b0, 1'b0));
      send_txn(make_req(5, 65535, 400, 1'b1, 1'b0, 1'b0));
      // flight channel past its deadline: override run at frame end
      send_txn(make_req(2, 1200, 400, 1'b0, 1'b0, 1'b1));
      send_txn(make_req(3, 5000, 1000, 1'b1, 1'b0, 1'b0));
      send_txn(make_req(17, 1500, 1000, 1'b1, 1'b1, 1'b1));
      send_txn(make_req(6, 1500, 1000, 1'b1, 1'b1, 1'b1));
      send_txn(make_req(18, 1500, 1000, 1'b1, 1'b0, 1'b1));
      send_txn(make_req(31, 65535, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
      // deadline saturates near the top of the time range
      send_txn(make_req(0, 1500, 32'hFFFF_FF00, 1'b1, 1'b0, 1'b0));
      send_txn(make_req(0, 0, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b1));
      send_txn(make_req(1, 1000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1));
      drain_results();
   endtask

   task automatic test_register_extremes();
      cfg_type c;
      c.pulse_min_us     = '0;
      c.pulse_max_us     = '1;
      c.mid_us           = '0;
      c.hold_ms          = '0;
      c.three_d_mode     = 1'b1;
      c.failsafe_enabled = 1'b0;
      c.averaging_mode   = 1'b0;
      c.channel_count    = '0;
      apply_cfg(c);
      send_txn(make_req(0, 0, 5000, 1'b1, 1'b1, 1'b0));
      send_txn(make_req(3, 4096, 5000, 1'b1, 1'b1, 1'b1));
      send_txn(make_req(3, 4095, 5001, 1'b1, 1'b1, 1'b1));
      drain_results();
      // empty window: nothing can be valid
      c.pulse_min_us     = '1;
      c.pulse_max_us     = '0;
      c.mid_us           = '1;
      c.hold_ms          = '1;
      c.three_d_mode     = 1'b0;
      c.failsafe_enabled = 1'b1;
      c.averaging_mode   = 1'b1;
      c.channel_count    = '1;
      apply_cfg(c);
      send_txn(make_req(2, 4095, 6000, 1'b1, 1'b0, 1'b0));
      send_txn(make_req(3, 2000, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
      send_txn(make_req(17, 65535, 7000, 1'b0, 1'b0, 1'b1));
      drain_results();
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      int pick;
      c.pulse_min_us     = US_W'($urandom_range(800, 1000));
      c.pulse_max_us     = US_W'($urandom_range(2000, 2200));
      c.mid_us           = US_W'($urandom_range(1400, 1600));
      pick = $urandom_range(0, 19);
      if (pick == 0)
         c.hold_ms = '0;
      else if (pick == 1)
         c.hold_ms = '1;
      else if (pick < 13)
         c.hold_ms = HOLD_W'($urandom_range(1, 100));
      else
         c.hold_ms = HOLD_W'($urandom_range(100, 400));
      c.three_d_mode     = 1'($urandom_range(0, 1));
      c.failsafe_enabled = 1'($urandom_range(0, 1));
      c.averaging_mode   = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick == 0)
         c.channel_count = '0;
      else if (pick == 1)
         c.channel_count = '1;
      else
         c.channel_count = CNT_W'($urandom_range(1, NUM_CH));
      return c;
   endfunction

   function automatic int pick_pulse();
      int pick;
      if (link_up && $urandom_range(0, 99) < 85)
         return $urandom_range(cfg_now.pulse_max_us, cfg_now.pulse_min_us);
      pick = $urandom_range(0, 2);
      if (pick == 0)
         return $urandom_range(0, cfg_now.pulse_min_us - 1);
      if (pick == 1)
         return $urandom_range(cfg_now.pulse_max_us + 1, 65535);
      return $urandom_range(0, 65535);
   endfunction

   // whole frames with random content, mixed with stray transactions
   task automatic test_random_frames();
      int      sent;
      int      len;
      bit      sw;
      bit      drop_end;
      req_type r;
      frame_ms = 32'd20000;
      for (int phase = 0; phase < 7; phase++) begin
         apply_cfg(random_cfg());
         req_idle_on = (phase != 3);
         rsp_idle_on = (phase != 3);
         sent = 0;
         while (sent < 40) begin
            if ($urandom_range(0, 99) < 80) begin
               len = int'(cfg_now.channel_count);
               if (len == 0 || len > NUM_CH)
                  len = $urandom_range(1, NUM_CH);
               frame_ms += $urandom_range(15, 25);
               if ($urandom_range(0, 9) == 0)
                  link_up = !link_up;
               sw       = ($urandom_range(0, 9) == 0);
               drop_end = ($urandom_range(0, 19) == 0);
               for (int ch = 0; ch < len; ch++) begin
                  r = make_req(ch, pick_pulse(), frame_ms + ch/6,
                               link_up && ($urandom_range(0, 99) >= 3), sw,
                               (ch == len - 1) && !drop_end);
                  send_txn(r);
                  sent++;
               end
            end else begin
               r.chan_index      = CHAN_W'($urandom_range(0, 31));
               r.pulse_us        = VAL_W'($urandom_range(0, 65535));
               r.now_ms          = ($urandom_range(0, 9) == 0) ? $urandom()
                                   : frame_ms + $urandom_range(0, 40);
               r.link_ok         = 1'($urandom_range(0, 1));
               r.failsafe_switch = 1'($urandom_range(0, 1));
               r.frame_end       = ($urandom_range(0, 3) == 0);
               send_txn(r);
               sent++;
            end
         end
         drain_results();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      clear_filter_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_averaging_warmup();
      test_signal_loss_directed();
      test_register_extremes();
      test_random_frames();
      repeat (48) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
